@@ rtl/rygb_to_cubemap_uv_assert.svh @@
// assertion macros for the cube map projection block
// used by rygb_to_cubemap_uv only
`ifndef RYGB_TO_CUBEMAP_UV_ASSERT_SVH
`define RYGB_TO_CUBEMAP_UV_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define RC_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("check failed");
// next-cycle implication
`define RC_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("check failed");
`endif

@@ rtl/rcuv_pkg.sv @@
// shared constants and types for the cube map projection block
// no dependencies
package rcuv_pkg;
	localparam int FRAC_BITS = 16;
	localparam int EXTRA_BITS = 14;
	localparam int K_A = 4843165;
	localparam int K_A3 = 14529495;
	localparam int K_C = 6849270;
	localparam int K_C2 = 13698540;
	localparam int K_S = 11863283;
	localparam int R00 = 16551520;
	localparam int R01 = 165068;
	localparam int R02 = 2737685;
	localparam int R11 = 16656490;
	localparam int R12 = 2002263;
	localparam int R22 = 16430794;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;
	localparam int QCW = 3;
	localparam int DIV_STEPS = 17;
	localparam int SQ_STEPS = 32;

	// one classified item passed from the front to the back
	typedef struct packed {
		logic [17:0] lum;
		logic [63:0] sumsq;
		logic [34:0] s_num;
		logic [34:0] t_num;
		logic [34:0] d_u;
		logic [34:0] d_v;
		logic        degen;
	} item_t;

	function automatic logic signed [63:0] rshift(input logic signed [63:0] v, input int s);
		logic [63:0] m;
		logic [63:0] r;
		begin
			m = v[63] ? 64'(-v) : 64'(v);
			r = (m + (64'd1 << (s - 1))) >> s;
			rshift = v[63] ? -$signed(r) : $signed(r);
		end
	endfunction
endpackage

@@ rtl/rygb_to_cubemap_uv.sv @@
// rygb color to cube map grid coordinates, top level
// depends on rcuv_pkg, rcuv_front, rcuv_queue, rcuv_back and the assertion header
// One color enters per cycle when the output is not stalled: three front
// stages form the opponent vector, the
// rotated vector and the face classification, a four-entry queue decouples
// the parts, and a 32-stage back pipeline runs the u/v restoring dividers
// beside the one-bit-per-stage square root for saturation. Throughput is one
// per cycle while the output accepts.
`include "rygb_to_cubemap_uv_assert.svh"
module rygb_to_cubemap_uv (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // chan_r, chan_y, chan_g, chan_b, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // tex_u, tex_v, lum, sat, zero fill
	output logic        m_axis_tuser   // degenerate
);
	logic fv, fr, qv, qr;
	rcuv_pkg::item_t fi, qi;
	logic [16:0] u, v;
	logic [17:0] l, s;

	rcuv_front u_front (.clk, .arst_n, .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.r(s_axis_tdata[16:0]), .y(s_axis_tdata[33:17]), .g(s_axis_tdata[50:34]),
		.b(s_axis_tdata[67:51]), .out_valid(fv), .out_ready(fr), .out_item(fi));
	rcuv_queue u_queue (.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_item(fi),
		.rd_valid(qv), .rd_ready(qr), .rd_item(qi));
	rcuv_back u_back (.clk, .arst_n, .in_valid(qv), .in_ready(qr), .in_item(qi),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .tex_u(u), .tex_v(v),
		.lum(l), .sat(s), .degen(m_axis_tuser));
	assign m_axis_tdata = {2'b00, s, l, v, u};

	`RC_ASSERT_IMP(a_degen_zero_uv, m_axis_tvalid && m_axis_tuser, m_axis_tdata[33:0] == 34'd0)
	`RC_ASSERT_NXT(a_hold_out, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`RC_ASSERT_IMP(a_u_range, m_axis_tvalid, m_axis_tdata[16:0] <= 17'h10000)
endmodule

@@ rtl/rcuv_front.sv @@
// front: opponent transform, rotation and face classification
// depends on rcuv_pkg
module rcuv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [16:0]         r,
	input  logic [16:0]         y,
	input  logic [16:0]         g,
	input  logic [16:0]         b,
	output logic                out_valid,
	input  logic                out_ready,
	output rcuv_pkg::item_t     out_item
);
	logic v_s1, v_s2, v_s3;
	logic [17:0] lum_s1, lum_s2;
	logic signed [31:0] h1_s1, h2_s1, h3_s1;
	logic signed [63:0] a1, a2, a3;
	logic signed [63:0] p1, p2, p3;
	logic signed [32:0] px_s2, py_s2, pz_s2;
	logic [63:0] sq_s2;
	logic [31:0] ax, ay, az, d;
	logic signed [32:0] s, t;
	logic [1:0] col, row;
	logic adv2, adv3;
	rcuv_pkg::item_t it_s3;

	assign adv3 = !v_s3 || out_ready;
	assign adv2 = !v_s2 || adv3;
	assign in_ready = !v_s1 || adv2;

	always_comb begin
		a1 = -64'(rcuv_pkg::K_A) * (64'(r) + 64'(y) + 64'(g)) + 64'(rcuv_pkg::K_A3) * 64'(b);
		a2 = -64'(rcuv_pkg::K_C) * (64'(r) + 64'(y)) + 64'(rcuv_pkg::K_C2) * 64'(g);
		a3 = 64'(rcuv_pkg::K_S) * (64'(y) - 64'(r));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (in_ready) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (in_ready) begin
			lum_s1 <= 18'((19'(r) + 19'(y) + 19'(g) + 19'(b) + 19'd1) >> 1);
			h1_s1 <= 32'(rcuv_pkg::rshift(a1, 10));
			h2_s1 <= 32'(rcuv_pkg::rshift(a2, 10));
			h3_s1 <= 32'(rcuv_pkg::rshift(a3, 10));
		end
	end

	always_comb begin
		p1 = 64'(rcuv_pkg::R00) * 64'(h1_s1) + 64'(rcuv_pkg::R01) * 64'(h2_s1)
			- 64'(rcuv_pkg::R02) * 64'(h3_s1);
		p2 = 64'(rcuv_pkg::R01) * 64'(h1_s1) + 64'(rcuv_pkg::R11) * 64'(h2_s1)
			+ 64'(rcuv_pkg::R12) * 64'(h3_s1);
		p3 = 64'(rcuv_pkg::R02) * 64'(h1_s1) - 64'(rcuv_pkg::R12) * 64'(h2_s1)
			+ 64'(rcuv_pkg::R22) * 64'(h3_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv2) begin
			lum_s2 <= lum_s1;
			px_s2 <= 33'(rcuv_pkg::rshift(p1, 24));
			py_s2 <= 33'(rcuv_pkg::rshift(p2, 24));
			pz_s2 <= 33'(rcuv_pkg::rshift(p3, 24));
			sq_s2 <= $unsigned(64'(h1_s1) * 64'(h1_s1) + 64'(h2_s1) * 64'(h2_s1)
				+ 64'(h3_s1) * 64'(h3_s1));
		end
	end

	always_comb begin
		ax = 32'(px_s2[32] ? -px_s2 : px_s2);
		ay = 32'(py_s2[32] ? -py_s2 : py_s2);
		az = 32'(pz_s2[32] ? -pz_s2 : pz_s2);
		d = (ax > ay) ? ax : ay;
		if (az > d) d = az;
		col = 2'd1;
		row = 2'd1;
		if (ax > ay && ax > az) begin
			if (!px_s2[32] && px_s2 != 0) begin s = -pz_s2; col = 2'd2; end
			else begin s = pz_s2; col = 2'd0; end
			t = py_s2;
		end else if (ay > ax && ay > az) begin
			if (!py_s2[32] && py_s2 != 0) begin t = -pz_s2; row = 2'd2; end
			else begin t = pz_s2; row = 2'd0; end
			s = px_s2;
		end else begin
			if (!pz_s2[32] && pz_s2 != 0) begin s = px_s2; col = 2'd1; end
			else begin s = -px_s2; col = 2'd3; end
			t = py_s2;
		end
		it_s3.lum = lum_s2;
		it_s3.sumsq = sq_s2;
		// numerators stay non-negative since |s| <= d
		it_s3.s_num = 35'(36'(s) + 36'(d) * (36'(col) * 36'd2 + 36'd1));
		it_s3.t_num = 35'(36'(t) + 36'(d) * (36'(row) * 36'd2 + 36'd1));
		it_s3.d_u = 35'(d) << 3;
		it_s3.d_v = 35'(36'(d) * 36'd6);
		it_s3.degen = (d == 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv3) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv3) out_item <= it_s3;
	end
	assign out_valid = v_s3;
endmodule

@@ rtl/rcuv_queue.sv @@
// short fifo between front and back
// depends on rcuv_pkg
module rcuv_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  rcuv_pkg::item_t wr_item,
	output logic            rd_valid,
	input  logic            rd_ready,
	output rcuv_pkg::item_t rd_item
);
	rcuv_pkg::item_t mem [rcuv_pkg::QDEPTH];
	logic [rcuv_pkg::QAW-1:0] wp_q, rp_q;
	logic [rcuv_pkg::QCW-1:0] cnt_q;
	logic wr, rd;

	function automatic logic [rcuv_pkg::QCW-1:0] QCWx(input logic v);
		QCWx = {{(rcuv_pkg::QCW-1){1'b0}}, v};
	endfunction

	assign wr_ready = cnt_q != rcuv_pkg::QCW'(rcuv_pkg::QDEPTH);
	assign rd_valid = cnt_q != 0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_item = mem[rp_q];
	always_ff @(posedge clk) begin
		if (wr) mem[wp_q] <= wr_item;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + QCWx(wr) - QCWx(rd);
		end
	end
endmodule

@@ rtl/rcuv_back.sv @@
// back: pipelined dividers for u, v and pipelined square root for sat
// depends on rcuv_pkg
module rcuv_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rcuv_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [16:0]     tex_u,
	output logic [16:0]     tex_v,
	output logic [17:0]     lum,
	output logic [17:0]     sat,
	output logic            degen
);
	localparam int N = rcuv_pkg::SQ_STEPS;
	localparam int DN = rcuv_pkg::DIV_STEPS;
	// divider: quotient of (num<<16 + den/2)/den, 17 quotient bits suffice
	logic            vld [N+1];
	logic [51:0]     urem [N+1];
	logic [51:0]     vrem [N+1];
	logic [19:0]     uq [N+1];
	logic [19:0]     vq [N+1];
	logic [34:0]     ud [N+1];
	logic [34:0]     vd [N+1];
	logic [63:0]     sn [N+1];
	logic [63:0]     sr [N+1];
	logic [17:0]     lm [N+1];
	logic            dg [N+1];
	logic            adv;
	logic [63:0]     sq_bit [N];

	assign adv = !vld[N] || out_ready;
	assign in_ready = adv;

	always_comb begin
		vld[0] = in_valid;
		ud[0] = in_item.d_u;
		vd[0] = in_item.d_v;
		urem[0] = (52'(in_item.s_num) << rcuv_pkg::FRAC_BITS) + 52'(in_item.d_u >> 1);
		vrem[0] = (52'(in_item.t_num) << rcuv_pkg::FRAC_BITS) + 52'(in_item.d_v >> 1);
		uq[0] = '0;
		vq[0] = '0;
		sn[0] = in_item.sumsq;
		sr[0] = '0;
		lm[0] = in_item.lum;
		dg[0] = in_item.degen;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [51:0] ut, vt;
		logic [63:0] tr;
		logic        nu, nv;
		assign sq_bit[i] = 64'd1 << (2 * (N - 1 - i));
		always_comb begin
			nu = 1'b0; nv = 1'b0; ut = urem[i]; vt = vrem[i];
			if (i >= N - DN) begin
				if (urem[i] >= (52'(ud[i]) << (N - 1 - i))) begin
					nu = 1'b1; ut = urem[i] - (52'(ud[i]) << (N - 1 - i));
				end
				if (vrem[i] >= (52'(vd[i]) << (N - 1 - i))) begin
					nv = 1'b1; vt = vrem[i] - (52'(vd[i]) << (N - 1 - i));
				end
			end
			tr = sr[i] + sq_bit[i];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld[i+1] <= 1'b0;
			else if (adv) vld[i+1] <= vld[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				urem[i+1] <= ut; vrem[i+1] <= vt;
				uq[i+1] <= {uq[i][18:0], nu};
				vq[i+1] <= {vq[i][18:0], nv};
				ud[i+1] <= ud[i]; vd[i+1] <= vd[i];
				lm[i+1] <= lm[i]; dg[i+1] <= dg[i];
				if (sn[i] >= tr) begin
					sn[i+1] <= sn[i] - tr;
					sr[i+1] <= (sr[i] >> 1) + sq_bit[i];
				end else begin
					sn[i+1] <= sn[i];
					sr[i+1] <= sr[i] >> 1;
				end
			end
		end
	end

	logic [64:0] satr;
	assign satr = (65'(sr[N]) + 65'(1 << (rcuv_pkg::EXTRA_BITS - 1))) >> rcuv_pkg::EXTRA_BITS;
	assign out_valid = vld[N];
	assign tex_u = dg[N] ? 17'd0 : uq[N][16:0];
	assign tex_v = dg[N] ? 17'd0 : vq[N][16:0];
	assign lum = lm[N];
	assign sat = (satr > 65'h3FFFF) ? 18'h3FFFF : satr[17:0];
	assign degen = dg[N];
endmodule
